// File: rtl/suks_pkg.sv
// ----------------------------------------------------------------------------
// suks_pkg
// types, codes and sizes shared by the sorted key set and its cells
// ----------------------------------------------------------------------------
package suks_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_BITS = 32;
  localparam int CNT_BITS = $clog2(CAPACITY + 1);

  // operation codes
  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_CONTAINS = 2'd1;
  localparam logic [1:0] OP_PRED     = 2'd2;
  localparam logic [1:0] OP_SUCC     = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_MISS = 2'd3;

  typedef struct packed {
    logic        [1:0]          operation;
    logic signed [KEY_BITS-1:0] key;
  } req_t;

  typedef struct packed {
    logic        [1:0]          status;
    logic signed [KEY_BITS-1:0] match_value;
    logic        [CNT_BITS-1:0] entry_count;
    logic signed [KEY_BITS-1:0] smallest_key;
    logic signed [KEY_BITS-1:0] largest_key;
  } rsp_t;

  // per-cell compare result against the broadcast key
  typedef struct packed {
    logic eq;
    logic lt;  // stored key below the broadcast key
    logic gt;  // stored key above the broadcast key
  } cell_flags_t;

  // control broadcast to every cell
  typedef struct packed {
    logic cmp_en;
    logic wr_en;
  } cell_ctl_t;

endpackage

// File: rtl/suks_cell.sv
// ----------------------------------------------------------------------------
// suks_cell
// one slot of the sorted row: holds a key, compares it, shifts up on insert
// ----------------------------------------------------------------------------
module suks_cell (
  input  logic                                 clk,
  input  suks_pkg::cell_ctl_t                  ctl,
  input  logic                                 occ,
  input  logic signed [suks_pkg::KEY_BITS-1:0] cmd_key,
  input  logic signed [suks_pkg::KEY_BITS-1:0] prev_key,
  input  logic                                 prev_ins,
  output logic signed [suks_pkg::KEY_BITS-1:0] key_q,
  output suks_pkg::cell_flags_t                flags,
  output logic                                 ins
);

  // at or above the insert point: holds a key not below the operand, or nothing
  assign ins = ~flags.lt;

  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      flags.eq <= occ & (key_q == cmd_key);
      flags.lt <= occ & (key_q < cmd_key);
      flags.gt <= occ & (key_q > cmd_key);
    end
    if (ctl.wr_en) begin
      if (prev_ins) begin
        key_q <= prev_key;
      end else if (ins) begin
        key_q <= cmd_key;
      end
    end
  end

endmodule

// File: rtl/sorted_unique_key_set.sv
// ----------------------------------------------------------------------------
// sorted_unique_key_set
// ordered set of distinct signed keys held in a row of compare/shift cells
// ----------------------------------------------------------------------------
// usage:
//   req channel (req_valid/req_ready/req) carries an operation and a key;
//   rsp channel (rsp_valid/rsp_ready/rsp) returns one item per request with
//   status, neighbor key, count, smallest and largest key.
//   operations: insert, contains, largest key below, smallest key above.
// timing:
//   an accepted item is latched, compared in every cell in the next cycle,
//   and resolved in S_EXEC once the result register is free, when the
//   result is registered. A new item is not accepted until the current
//   one has gone through the accept, compare and resolve/shift steps.
//   req_ready is high whenever no item is in flight, even while a result
//   waits on the rsp side; a stalled rsp holds the next item in its
//   resolve cycle until the result register frees up.
// reset:
//   rst (synchronous) empties the set and returns both handshakes to idle; the key
//   slots themselves are not cleared, only the count marks them valid.
// ----------------------------------------------------------------------------
module sorted_unique_key_set (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  suks_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output suks_pkg::rsp_t rsp
);

  localparam int CAP = suks_pkg::CAPACITY;
  localparam int KB  = suks_pkg::KEY_BITS;
  localparam int CB  = suks_pkg::CNT_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMPARE,
    S_EXEC
  } state_t;

  state_t                state;
  state_t                state_next;

  // latched command
  logic        [1:0]     cmd_op;
  logic signed [KB-1:0]  cmd_key;

  // set bookkeeping
  logic        [CB-1:0]  count;
  logic        [CB-1:0]  count_next;
  logic signed [KB-1:0]  min_key;
  logic signed [KB-1:0]  min_next;
  logic signed [KB-1:0]  max_key;
  logic signed [KB-1:0]  max_next;

  suks_pkg::rsp_t        rsp_next;
  suks_pkg::cell_ctl_t   ctl;

  // cell row
  logic signed [KB-1:0]  key_row   [CAP];
  suks_pkg::cell_flags_t flags_row [CAP];
  logic                  ins_row   [CAP];
  logic                  pred_sel  [CAP];
  logic                  succ_sel  [CAP];

  logic                  rsp_free;
  logic                  do_exec;
  logic                  any_eq;
  logic                  set_full;
  logic                  do_insert;
  logic                  nb_found;
  logic signed [KB-1:0]  nb_key;

  assign req_ready = (state == S_IDLE);
  assign rsp_free  = ~rsp_valid | rsp_ready;
  assign do_exec   = (state == S_EXEC) & rsp_free;

  assign ctl.cmp_en = (state == S_COMPARE);
  assign ctl.wr_en  = do_exec & do_insert;

  // row of cells, each handing its key up to the next on insert
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    localparam logic [CB-1:0] IDX = CB'(i);
    logic signed [KB-1:0] prev_key;
    logic                 prev_ins;

    if (i == 0) begin : g_first
      assign prev_key = '0;
      assign prev_ins = 1'b0;
      assign succ_sel[i] = flags_row[i].gt;
    end else begin : g_rest
      assign prev_key = key_row[i-1];
      assign prev_ins = ins_row[i-1];
      assign succ_sel[i] = flags_row[i].gt & ~flags_row[i-1].gt;
    end

    // last key below the operand: end of the run of lower keys
    if (i == CAP - 1) begin : g_last
      assign pred_sel[i] = flags_row[i].lt;
    end else begin : g_inner
      assign pred_sel[i] = flags_row[i].lt & ~flags_row[i+1].lt;
    end

    suks_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .occ      (IDX < count),
      .cmd_key  (cmd_key),
      .prev_key (prev_key),
      .prev_ins (prev_ins),
      .key_q    (key_row[i]),
      .flags    (flags_row[i]),
      .ins      (ins_row[i])
    );
  end

  // gather hits across the row
  always_comb begin
    any_eq   = 1'b0;
    nb_found = 1'b0;
    nb_key   = '0;
    for (int i = 0; i < CAP; i++) begin
      any_eq = any_eq | flags_row[i].eq;
      if (cmd_op == suks_pkg::OP_PRED) begin
        nb_found = nb_found | pred_sel[i];
        nb_key   = nb_key | ({KB{pred_sel[i]}} & key_row[i]);
      end else begin
        nb_found = nb_found | succ_sel[i];
        nb_key   = nb_key | ({KB{succ_sel[i]}} & key_row[i]);
      end
    end
  end

  // resolve the operation
  always_comb begin
    set_full   = (count == CB'(CAP));
    do_insert  = (cmd_op == suks_pkg::OP_INSERT) & ~any_eq & ~set_full;
    count_next = count;
    min_next   = min_key;
    max_next   = max_key;

    rsp_next.match_value = cmd_key;
    unique case (cmd_op)
      suks_pkg::OP_INSERT: begin
        priority if (any_eq) begin
          rsp_next.status = suks_pkg::ST_DUP;
        end else if (set_full) begin
          rsp_next.status = suks_pkg::ST_FULL;
        end else begin
          rsp_next.status = suks_pkg::ST_OK;
        end
      end
      suks_pkg::OP_CONTAINS: begin
        rsp_next.status = any_eq ? suks_pkg::ST_OK : suks_pkg::ST_MISS;
      end
      suks_pkg::OP_PRED, suks_pkg::OP_SUCC: begin
        rsp_next.status = nb_found ? suks_pkg::ST_OK : suks_pkg::ST_MISS;
        if (nb_found) begin
          rsp_next.match_value = nb_key;
        end
      end
      default: begin
        rsp_next.status = suks_pkg::ST_MISS;
      end
    endcase

    if (do_insert) begin
      count_next = count + CB'(1);
      if (count == '0) begin
        min_next = cmd_key;
        max_next = cmd_key;
      end else begin
        if (cmd_key < min_key) begin
          min_next = cmd_key;
        end
        if (cmd_key > max_key) begin
          max_next = cmd_key;
        end
      end
    end

    rsp_next.entry_count  = count_next;
    rsp_next.smallest_key = (count_next == '0) ? '0 : min_next;
    rsp_next.largest_key  = (count_next == '0) ? '0 : max_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_COMPARE;
        end
      end
      S_COMPARE: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      count     <= '0;
    end else begin
      state <= state_next;
      if (do_exec) begin
        rsp_valid <= 1'b1;
        count     <= count_next;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
    if (req_valid & req_ready) begin
      cmd_op  <= req.operation;
      cmd_key <= req.key;
    end
    if (do_exec) begin
      rsp     <= rsp_next;
      min_key <= min_next;
      max_key <= max_next;
    end
  end

endmodule

// File: bench/sorted_unique_key_set_tb.sv
// ----------------------------------------------------------------------------
// sorted_unique_key_set_tb
// self-checking bench for the sorted unique key set: a queue-fed driver
// offers insert/contains/neighbor items, a shadow copy of the sorted set
// predicts every response, and a monitor compares them field by field
// under random stalls on both channels
// ----------------------------------------------------------------------------
module sorted_unique_key_set_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KB = suks_pkg::KEY_BITS;

  localparam logic signed [KB-1:0] KEY_MIN = {1'b1, {(KB-1){1'b0}}};
  localparam logic signed [KB-1:0] KEY_MAX = {1'b0, {(KB-1){1'b1}}};
  // cycles with no item moving on either channel before giving up
  localparam int STALL_LIMIT = 4000;
  // length of the forced receiver hold-off
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  suks_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  suks_pkg::rsp_t rsp;

  sorted_unique_key_set u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // items waiting to be offered, and responses waiting to arrive
  suks_pkg::req_t pending_items[$];
  suks_pkg::rsp_t expected_rsps[$];
  // every key ever offered for insert, reused to hit stored keys and neighbors
  logic signed [KB-1:0] inserted_keys[$];

  // shadow copy of the set, kept in ascending order
  logic signed [KB-1:0] shadow_keys[suks_pkg::CAPACITY];
  int shadow_count = 0;

  // idle percentages for each side, changed between phases
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // receiver hold-off requests from the sequencer, served by the monitor
  int hold_requests = 0;
  int holds_taken = 0;
  int hold_left = 0;

  int mismatches = 0;
  int results_seen = 0;
  int quiet_cycles = 0;

  // apply one item to the shadow set and return the response it should give
  function automatic suks_pkg::rsp_t apply_to_shadow(suks_pkg::req_t item);
    suks_pkg::rsp_t res;
    logic signed [KB-1:0] k;
    int below;
    bit present;
    k = item.key;
    // keys are sorted, so the count of smaller keys is the insert position
    below = 0;
    for (int i = 0; i < shadow_count; i++)
      if (shadow_keys[i] < k) below++;
    present = (below < shadow_count) && (shadow_keys[below] == k);

    res = '0;
    res.match_value = k;
    case (item.operation)
      suks_pkg::OP_INSERT: begin
        if (present) begin
          res.status = suks_pkg::ST_DUP;
        end else if (shadow_count >= suks_pkg::CAPACITY) begin
          res.status = suks_pkg::ST_FULL;
        end else begin
          for (int i = shadow_count; i > below; i--)
            shadow_keys[i] = shadow_keys[i-1];
          shadow_keys[below] = k;
          shadow_count++;
          res.status = suks_pkg::ST_OK;
        end
      end
      suks_pkg::OP_CONTAINS: begin
        res.status = present ? suks_pkg::ST_OK : suks_pkg::ST_MISS;
      end
      suks_pkg::OP_PRED: begin
        res.status = suks_pkg::ST_MISS;
        if (below > 0) begin
          res.status = suks_pkg::ST_OK;
          res.match_value = shadow_keys[below-1];
        end
      end
      default: begin
        // first key strictly above: skip the equal key if it is stored
        res.status = suks_pkg::ST_MISS;
        if (below + present < shadow_count) begin
          res.status = suks_pkg::ST_OK;
          res.match_value = shadow_keys[below + present];
        end
      end
    endcase

    res.entry_count = suks_pkg::CNT_BITS'(shadow_count);
    // an empty set reports zero for both ends
    if (shadow_count > 0) begin
      res.smallest_key = shadow_keys[0];
      res.largest_key = shadow_keys[shadow_count-1];
    end
    return res;
  endfunction

  // key source: wide random, a narrow band around zero, extremes,
  // and keys at or next to ones already offered for insert
  function automatic logic signed [KB-1:0] pick_key();
    int pick;
    logic signed [KB-1:0] k;
    pick = $urandom_range(99);
    if (pick < 30 || inserted_keys.size() == 0) begin
      k = $urandom;
    end else if (pick < 50) begin
      k = $urandom_range(40) - 20;
    end else if (pick < 60) begin
      case ($urandom_range(5))
        0: k = KEY_MIN;
        1: k = KEY_MIN + 1;
        2: k = KEY_MAX;
        3: k = KEY_MAX - 1;
        4: k = '0;
        default: k = '1;
      endcase
    end else begin
      k = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
      case ($urandom_range(3))
        0: k = k - 1;
        1: k = k + 1;
        default: ;
      endcase
    end
    return k;
  endfunction

  task automatic queue_item(logic [1:0] op, logic signed [KB-1:0] k);
    suks_pkg::req_t item;
    item.operation = op;
    item.key = k;
    pending_items.push_back(item);
    if (op == suks_pkg::OP_INSERT) inserted_keys.push_back(k);
  endtask

  // inserts are a quarter of the mix so the set fills partway through the
  // run, leaving room for refused inserts and duplicates while full
  task automatic queue_random(int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 25) queue_item(suks_pkg::OP_INSERT, pick_key());
      else if (pick < 50) queue_item(suks_pkg::OP_CONTAINS, pick_key());
      else if (pick < 75) queue_item(suks_pkg::OP_PRED, pick_key());
      else queue_item(suks_pkg::OP_SUCC, pick_key());
    end
  endtask

  // sender pauses here until every item is accepted and answered
  task automatic wait_drained();
    while (pending_items.size() != 0 || req_valid || expected_rsps.size() != 0)
      @(negedge clk);
  endtask

  task automatic report_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // driver: predicts on acceptance, then offers the next item or idles
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) expected_rsps.push_back(apply_to_shadow(req));
      // payload only moves once the current item is gone
      if (!req_valid || req_ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req <= pending_items.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each response against the oldest prediction
  always @(posedge clk) begin
    suks_pkg::rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        results_seen++;
        if (expected_rsps.size() == 0) begin
          report_error($sformatf("result %0d arrived with nothing expected",
                                 results_seen));
        end else begin
          want = expected_rsps.pop_front();
          if (rsp !== want)
            report_error($sformatf(
              {"result %0d mismatch: expected status %0d match %0d count %0d",
               " min %0d max %0d, got status %0d match %0d count %0d min %0d max %0d"},
              results_seen, want.status, want.match_value, want.entry_count,
              want.smallest_key, want.largest_key, rsp.status, rsp.match_value,
              rsp.entry_count, rsp.smallest_key, rsp.largest_key));
        end
      end
      // a long hold-off backs the block up until it stops taking items
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rsp_ready <= 1'b0;
      end else if (holds_taken != hold_requests) begin
        holds_taken <= hold_requests;
        hold_left <= HOLD_CYCLES;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog: ends the run when no item moves for too long
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("sorted_unique_key_set regression: fail");
      $finish;
    end
  end

  initial begin
    send_idle_pct = 19;
    recv_idle_pct = 73;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty set queries, extremes, duplicates, neighbor edges
    queue_item(suks_pkg::OP_PRED, '0);              // empty set, no neighbor
    queue_item(suks_pkg::OP_SUCC, '0);
    queue_item(suks_pkg::OP_CONTAINS, '0);          // miss on empty set
    queue_item(suks_pkg::OP_INSERT, '0);
    queue_item(suks_pkg::OP_INSERT, KEY_MIN);
    queue_item(suks_pkg::OP_INSERT, KEY_MAX);
    queue_item(suks_pkg::OP_INSERT, '1);
    queue_item(suks_pkg::OP_INSERT, 1);
    queue_item(suks_pkg::OP_INSERT, KEY_MIN);       // duplicate at the low end
    queue_item(suks_pkg::OP_INSERT, '0);            // duplicate in the middle
    queue_item(suks_pkg::OP_CONTAINS, KEY_MAX);
    queue_item(suks_pkg::OP_CONTAINS, 2);
    queue_item(suks_pkg::OP_PRED, KEY_MIN);         // nothing below the minimum
    queue_item(suks_pkg::OP_SUCC, KEY_MAX);         // nothing above the maximum
    queue_item(suks_pkg::OP_PRED, KEY_MAX);
    queue_item(suks_pkg::OP_SUCC, KEY_MIN);
    queue_item(suks_pkg::OP_PRED, '0);
    queue_item(suks_pkg::OP_SUCC, '0);
    queue_item(suks_pkg::OP_PRED, KEY_MIN + 1);
    queue_item(suks_pkg::OP_SUCC, KEY_MAX - 1);
    queue_item(suks_pkg::OP_INSERT, 32'sh5555_5555);
    queue_item(suks_pkg::OP_INSERT, 32'shaaaa_aaaa);
    queue_item(suks_pkg::OP_CONTAINS, 32'shaaaa_aaaa);
    wait_drained();

    // phase one: sender idles a little, receiver idles a lot
    queue_random(250);
    wait_drained();

    // phase two: the other way round
    send_idle_pct = 73;
    recv_idle_pct = 19;
    queue_random(250);
    wait_drained();

    // phase three: no idling, with one long receiver hold-off up front
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests = hold_requests + 1;
    queue_random(200);
    wait_drained();

    repeat (20) @(posedge clk);
    if (expected_rsps.size() != 0)
      report_error($sformatf("%0d results never arrived", expected_rsps.size()));
    if (mismatches == 0) begin
      $display("sorted_unique_key_set regression: pass");
    end else begin
      $display("sorted_unique_key_set regression: fail");
    end
    $finish;
  end

endmodule
